// File: hdl/xcj_pkg.sv
// xcj_pkg: shared types and constants of the x86 call/jump address decoder.
// No dependencies; compiled first.
package xcj_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POS_W      = 63;
    localparam int unsigned IDX_W      = 64;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned ADDR_BITS  = 24;

    localparam logic [BYTE_W-1:0] OPC_CALL = 8'hE8;
    localparam logic [BYTE_W-1:0] OPC_JMP  = 8'hE9;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_POSITION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_E9      = 8'd1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        cnt_m1;
        logic              last;
        logic              conv;
        logic [IDX_W-1:0]  cur;
    } t_job;

endpackage

// File: hdl/xcj_if.sv
// Channel interfaces of the decoder: input bytes, output bytes, register writes.
// Depends on xcj_pkg.
interface xcj_in_if;
    logic                       valid;
    logic                       ready;
    logic [xcj_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xcj_out_if;
    logic                       valid;
    logic                       ready;
    logic [xcj_pkg::BYTE_W-1:0] out_byte;
    logic                       out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface xcj_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [xcj_pkg::CFG_IDX_W-1:0]  index;
    logic [xcj_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/x86_call_jump_address_decoder_top.sv
// x86_call_jump_address_decoder_top: front, job queue and back of the decoder.
// Depends on xcj_pkg, xcj_if, xcj_front, xcj_queue, xcj_back.
//
// Use: bytes of a filtered block enter on i_in, one per item, in_last on the
// final byte. Decoded bytes leave on o_out in the same order with out_last on
// the final one. i_cfg writes block_position (index 0) and accept_e9 (index 1)
// while the block is idle; it is always ready.
// Path: a byte that passes directly goes through a job queue entry and then
// the back part's output register before it is offered on o_out. An opcode's
// four address bytes are held until the fourth arrives, then leave as a group
// of four through the same path, one per cycle while o_out.ready is high.
// Throughput: one input item per cycle while the job queue is not full, set
// by the single-byte output register of the back part; groups of four drain
// through the QUEUE_DEPTH-entry queue, so the long-run rate stays at one byte per cycle.
// Reset: synchronous, clears position, mode, held bytes and the queue.
// Stall: when o_out.ready is low the back part holds its byte; i_in.ready drops
// only once the job queue is full.
module x86_call_jump_address_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    xcj_in_if.sink   i_in,
    xcj_cfg_if.sink  i_cfg,
    xcj_out_if.source o_out
);
    import xcj_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic full;
    logic head_valid;
    logic pop;

    xcj_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    xcj_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    xcj_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: hdl/xcj_front.sv
// xcj_front: accepts bytes, finds opcodes, gathers address bytes into jobs.
// Holds the configuration registers. Depends on xcj_pkg and xcj_if.
module xcj_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xcj_in_if.sink        i_in,
    xcj_cfg_if.sink       i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output xcj_pkg::t_job o_job
);
    import xcj_pkg::*;

    logic [POS_W-1:0]  r_bp;
    logic              r_e9;
    logic [IDX_W-1:0]  r_idx1, n_idx1;
    logic              r_collect, n_collect;
    logic [1:0]        r_cnt, n_cnt;
    logic [23:0]       r_held, n_held;
    logic              accept;
    logic              opcode;
    logic [IDX_W-1:0]  cur;
    logic [BYTE_W-1:0] b;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_full;
    assign b           = i_in.in_byte;
    assign opcode      = (b == OPC_CALL) || (r_e9 && (b == OPC_JMP));
    assign cur         = {1'b0, r_bp} + r_idx1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp <= '0;
            r_e9 <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_BLOCK_POSITION: r_bp <= i_cfg.data[POS_W-1:0];
                REG_ACCEPT_E9:      r_e9 <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_idx1    = r_idx1;
        n_collect = r_collect;
        n_cnt     = r_cnt;
        n_held    = r_held;
        o_push    = 1'b0;
        o_job     = '{word: '0, cnt_m1: 2'd0, last: i_in.in_last, conv: 1'b0, cur: cur};
        if (accept) begin
            if (r_collect) begin
                if (r_cnt == 2'd3) begin
                    o_push       = 1'b1;
                    o_job.word   = {b, r_held};
                    o_job.cnt_m1 = 2'd3;
                    o_job.conv   = 1'b1;
                    n_collect    = 1'b0;
                    n_cnt        = 2'd0;
                    n_held       = '0;
                end else if (i_in.in_last) begin
                    o_push       = 1'b1;
                    o_job.word   = {8'd0, r_held} | ({24'd0, b} << {r_cnt, 3'b000});
                    o_job.cnt_m1 = r_cnt;
                end else begin
                    n_held = r_held | ({16'd0, b} << {r_cnt, 3'b000});
                    n_cnt  = r_cnt + 2'd1;
                end
            end else begin
                o_push     = 1'b1;
                o_job.word = {24'd0, b};
                if (!i_in.in_last && opcode) begin
                    n_collect = 1'b1;
                    n_cnt     = 2'd0;
                    n_held    = '0;
                end
            end
            if (i_in.in_last) begin
                n_idx1    = IDX_W'(1);
                n_collect = 1'b0;
                n_cnt     = 2'd0;
                n_held    = '0;
            end else begin
                n_idx1 = r_idx1 + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx1    <= IDX_W'(1);
            r_collect <= 1'b0;
            r_cnt     <= 2'd0;
            r_held    <= '0;
        end else begin
            r_idx1    <= n_idx1;
            r_collect <= n_collect;
            r_cnt     <= n_cnt;
            r_held    <= n_held;
        end
    end

endmodule

// File: hdl/xcj_queue.sv
// xcj_queue: small job FIFO between the front and back parts.
// Depends on xcj_pkg.
module xcj_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xcj_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output xcj_pkg::t_job o_job
);
    import xcj_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: hdl/xcj_back.sv
// xcj_back: range-checks and converts addresses, then sends job bytes out one
// per cycle while o_out.ready is high. Depends on xcj_pkg and xcj_if.
module xcj_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  xcj_pkg::t_job i_job,
    output logic          o_pop,
    xcj_out_if.source     o_out
);
    import xcj_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [2:0]        r_rem;
    logic              r_last;
    logic [IDX_W:0]    sum;
    logic              in_range;
    logic [WORD_W-1:0] result;
    logic              out_acc;

    assign sum      = {i_job.cur[IDX_W-1], i_job.cur}
                    + {{(IDX_W + 1 - WORD_W){i_job.word[WORD_W-1]}}, i_job.word};
    assign in_range = (sum[IDX_W:ADDR_BITS] == '0);
    assign result   = (i_job.conv && in_range) ? i_job.word - i_job.cur[WORD_W-1:0]
                                               : i_job.word;

    assign out_acc        = o_out.valid && o_out.ready;
    assign o_pop          = i_valid && ((r_rem == 3'd0) || ((r_rem == 3'd1) && out_acc));
    assign o_out.valid    = (r_rem != 3'd0);
    assign o_out.out_byte = r_word[BYTE_W-1:0];
    assign o_out.out_last = r_last && (r_rem == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 3'd0;
            r_last <= 1'b0;
        end else if (o_pop) begin
            r_rem  <= {1'b0, i_job.cnt_m1} + 3'd1;
            r_last <= i_job.last;
        end else if (out_acc) begin
            r_rem  <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= result;
        end else if (out_acc) begin
            r_word <= {8'd0, r_word[WORD_W-1:BYTE_W]};
        end
    end

endmodule

// File: hdl/xcj_checker.sv
// xcj_checker: port-level assertions for the decoder top level, with its bind.
// Depends on x86_call_jump_address_decoder_top.
module xcj_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output pending");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

endmodule

bind x86_call_jump_address_decoder_top xcj_checker u_xcj_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

// File: bench/x86_call_jump_address_decoder_top_tb.sv
// Testbench of x86_call_jump_address_decoder_top: directed and random byte blocks,
// each output byte checked against a decoder model kept in the bench.
// Depends on xcj_pkg, xcj_if and the decoder RTL.
module x86_call_jump_address_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcj_pkg::*;

    localparam logic [CFG_IDX_W-1:0]  REG_UNUSED   = 8'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_TOP      = 8'hFF;
    localparam logic [CFG_DATA_W-1:0] POS_MASK     = {1'b0, {POS_W{1'b1}}};
    localparam longint                ADDR_SPAN    = 64'sh0100_0000;
    localparam int                    SETTLE_CYCLES = 6;
    localparam int                    STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xcj_in_if  in_ch ();
    xcj_out_if out_ch ();
    xcj_cfg_if cfg_ch ();

    x86_call_jump_address_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // decoder model state
    logic [POS_W-1:0]  dec_position;
    logic              dec_accept_e9;
    logic [IDX_W-1:0]  dec_index;
    int                dec_held_cnt;
    logic [23:0]       dec_held;
    logic              dec_collecting;
    t_out_byte         expected_bytes[$];

    // stimulus side
    logic [CFG_DATA_W-1:0] cfg_position;
    logic [BYTE_W-1:0]     block_bytes[$];
    bit                    steady;
    int                    mismatches;
    int                    idle_cycles = 0;

    task automatic add_expected(input logic [BYTE_W-1:0] data, input logic last);
        t_out_byte item;
        item.data = data;
        item.last = last;
        expected_bytes.insert(expected_bytes.size(), item);
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b);
        block_bytes.insert(block_bytes.size(), b);
    endtask

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] want,
                                   input logic [BYTE_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  cu;
        longint            addr;
        longint            cur;
        if (dec_collecting) begin
            if (dec_held_cnt == 3) begin
                word = {b, dec_held};
                addr = longint'($signed(word));
                cu   = {1'b0, dec_position} + dec_index + 64'd1;
                cur  = longint'(cu);
                if (cur >= -addr && cur < ADDR_SPAN - addr)
                    word = word - cu[WORD_W-1:0];
                for (int k = 0; k < 4; k++)
                    add_expected(word[8*k +: 8], (k == 3) ? last : 1'b0);
                dec_held_cnt   = 0;
                dec_held       = '0;
                dec_collecting = 1'b0;
            end else if (last) begin
                for (int k = 0; k < dec_held_cnt; k++)
                    add_expected(dec_held[8*k +: 8], 1'b0);
                add_expected(b, 1'b1);
            end else begin
                dec_held[8*dec_held_cnt +: 8] = b;
                dec_held_cnt++;
            end
        end else begin
            add_expected(b, last);
            if (!last && (b == OPC_CALL || (dec_accept_e9 && b == OPC_JMP))) begin
                dec_collecting = 1'b1;
                dec_held_cnt   = 0;
                dec_held       = '0;
            end
        end
        if (last) begin
            dec_index      = '0;
            dec_held_cnt   = 0;
            dec_held       = '0;
            dec_collecting = 1'b0;
        end else begin
            dec_index = dec_index + 64'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_byte got;
        t_out_byte want;
        if (!i_rst_n) begin
            dec_position   = '0;
            dec_accept_e9  = 1'b0;
            dec_index      = '0;
            dec_held_cnt   = 0;
            dec_held       = '0;
            dec_collecting = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.in_byte, in_ch.in_last);
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_BLOCK_POSITION)
                    dec_position = cfg_ch.data[POS_W-1:0];
                else if (cfg_ch.index == REG_ACCEPT_E9)
                    dec_accept_e9 = cfg_ch.data[0];
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.out_byte, out_ch.out_last};
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", 'x, got.data);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data)
                        report_mismatch("out_byte", want.data, got.data);
                    if (got.last !== want.last)
                        report_mismatch("out_last", 8'(want.last), 8'(got.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
            send_byte(block_bytes[i], i == block_bytes.size() - 1);
        block_bytes.delete();
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        if (index == REG_BLOCK_POSITION)
            cfg_position = data & POS_MASK;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // address whose distance above -cur is off, for an opcode at opc_idx
    function automatic logic [WORD_W-1:0] addr_at(input int unsigned opc_idx,
                                                  input logic [63:0] off);
        logic [63:0] cur;
        cur = cfg_position + 64'(opc_idx) + 64'd5;
        return 32'(off - cur);
    endfunction

    function automatic logic [WORD_W-1:0] pick_addr(input int unsigned opc_idx);
        case ($urandom_range(0, 6))
            0:       return addr_at(opc_idx, 64'd0);
            1:       return addr_at(opc_idx, ADDR_SPAN - 1);
            2:       return addr_at(opc_idx, ADDR_SPAN);
            3:       return addr_at(opc_idx, '1);
            4, 5:    return addr_at(opc_idx, 64'($urandom_range(0, 32'hFF_FFFF)));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_call(input logic [BYTE_W-1:0] opc, input logic [WORD_W-1:0] addr);
        add_byte(opc);
        for (int k = 0; k < 4; k++)
            add_byte(addr[8*k +: 8]);
    endtask

    task automatic test_plain_and_call();
        write_reg(REG_BLOCK_POSITION, 64'h8000_0000_0000_0000);
        write_reg(REG_UNUSED, '1);
        write_reg(REG_TOP, '1);
        block_bytes = '{8'h00, 8'hFF};
        push_call(OPC_CALL, addr_at(block_bytes.size(), 64'd0));
        push_call(OPC_CALL, addr_at(block_bytes.size(), ADDR_SPAN));
        add_byte(8'h7F);
        send_block();
    endtask

    task automatic test_jump_mode();
        write_reg(REG_ACCEPT_E9, 64'd0);
        block_bytes = '{OPC_JMP, 8'h00};
        send_block();
        write_reg(REG_ACCEPT_E9, 64'd1);
        push_call(OPC_JMP, addr_at(0, ADDR_SPAN - 1));
        send_block();
    endtask

    task automatic test_early_end();
        block_bytes = '{OPC_CALL, 8'h11, 8'h22};
        send_block();
        block_bytes = '{OPC_CALL};
        send_block();
        block_bytes = '{OPC_CALL, 8'hAB};
        send_block();
    endtask

    task automatic test_position_extremes();
        write_reg(REG_BLOCK_POSITION, '1);
        block_bytes = '{OPC_CALL, OPC_CALL, OPC_CALL, OPC_CALL, OPC_CALL};
        send_block();
        write_reg(REG_BLOCK_POSITION, 64'h0000_0000_00FF_FFF0);
        push_call(OPC_CALL, addr_at(0, 64'($urandom_range(0, 32'hFF_FFFF))));
        send_block();
    endtask

    task automatic test_random_blocks(input int target);
        int sent;
        int goal;
        int cut;
        logic [BYTE_W-1:0] opc;
        sent = 0;
        while (sent < target) begin
            goal = $urandom_range(1, 14);
            while (block_bytes.size() < goal) begin
                opc = $urandom_range(0, 1) ? OPC_CALL : OPC_JMP;
                case ($urandom_range(0, 9))
                    0, 1, 2: push_call(opc, pick_addr(block_bytes.size()));
                    3: begin
                        add_byte(opc);
                        cut = $urandom_range(0, 3);
                        repeat (cut) add_byte(8'($urandom_range(0, 255)));
                        goal = 0;
                    end
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            sent += block_bytes.size();
            send_block();
        end
    endtask

    task automatic test_noise(input int count);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            b = ($urandom_range(0, 3) == 0) ? OPC_CALL : 8'($urandom_range(0, 255));
            send_byte(b, i == count - 1 || $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        t_out_byte pending;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        cfg_position  = '0;
        steady        = 1'b0;
        mismatches    = 0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_and_call();
        test_jump_mode();
        test_early_end();
        test_position_extremes();

        write_reg(REG_BLOCK_POSITION, 64'($urandom_range(0, 32'h10_0000)));
        write_reg(REG_ACCEPT_E9, 64'($urandom_range(0, 1)));
        test_random_blocks(15);

        write_reg(REG_BLOCK_POSITION, 64'd0);
        write_reg(REG_ACCEPT_E9, 64'd1);
        settle();
        steady = 1'b1;
        test_random_blocks(12);
        settle();
        steady = 1'b0;

        write_reg(REG_BLOCK_POSITION, {1'b0, 31'($urandom), 32'($urandom)});
        test_random_blocks(8);

        write_reg(REG_BLOCK_POSITION, 64'($urandom_range(0, 255)));
        write_reg(REG_ACCEPT_E9, 64'd0);
        test_noise(20);

        settle();
        while (expected_bytes.size() != 0) begin
            pending = expected_bytes.pop_front();
            report_mismatch("missing byte", pending.data, 'x);
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
